FILE: sv/bpc_pkg.sv
// Shared types, constants and arithmetic helpers for the pressure compensation pipeline.
package bpc_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_CAL = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;

  localparam logic [3:0] REG_CAL_A = 4'd0;
  localparam logic [3:0] REG_CAL_B = 4'd1;
  localparam logic [3:0] REG_CAL_C = 4'd2;
  localparam logic [3:0] REG_OSS   = 4'd3;

  localparam int DivW = 32;

  typedef struct packed {
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [1:0]  oss;
  } cal_t;

  // Divider stage payload: quotient/remainder state plus the fields riding along.
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] den;
    logic        neg;
  } div_t;

  function automatic logic [31:0] asr(input logic [31:0] v, input int n);
    asr = 32'($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

endpackage

FILE: sv/bpc_div.sv
// Pipelined restoring divider: one quotient bit per stage, one division enters per cycle.
module bpc_div #(
  parameter int Tw = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [31:0]   dividend,
  input  logic [31:0]   divisor,
  input  logic          negate,
  input  logic [Tw-1:0] in_tag,
  output logic          out_valid,
  output logic [31:0]   quotient,
  output logic [Tw-1:0] out_tag
);
  localparam int N = bpc_pkg::DivW;

  logic             vld [N+1];
  bpc_pkg::div_t    st  [N+1];
  logic [Tw-1:0]    tag [N+1];

  assign vld[0]          = in_valid;
  assign st[0].rem       = '0;
  assign st[0].quo       = dividend;
  assign st[0].den       = divisor;
  assign st[0].neg       = negate;
  assign tag[0]          = in_tag;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [32:0] trial;
    logic [31:0] shifted;
    assign shifted = {st[i].rem[30:0], st[i].quo[31]};
    assign trial   = {st[i].rem[31], shifted} - {1'b0, st[i].den};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      st[i+1].den <= st[i].den;
      st[i+1].neg <= st[i].neg;
      tag[i+1]    <= tag[i];
      if (!trial[32]) begin
        st[i+1].rem <= trial[31:0];
        st[i+1].quo <= {st[i].quo[30:0], 1'b1};
      end else begin
        st[i+1].rem <= shifted;
        st[i+1].quo <= {st[i].quo[30:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[N];
  assign quotient  = st[N].neg ? (32'd0 - st[N].quo) : st[N].quo;
  assign out_tag   = tag[N];
endmodule

FILE: sv/bpc_temp.sv
// Temperature front end: X1, divisor check, then the MC*2^11/(X1+MD) division and B5, T.
module bpc_temp #(
  parameter int Tw = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [15:0]     ut,
  input  bpc_pkg::cal_t   cal,
  input  logic [Tw-1:0]   in_tag,
  output logic            out_valid,
  output logic [31:0]     b5,
  output logic [31:0]     t,
  output logic [1:0]      status,
  output logic [Tw-1:0]   out_tag
);
  localparam int Pw = Tw + 32 + 2;

  // stage 1: multiply
  logic          v1;
  logic [31:0]   prod1;
  logic [Tw-1:0] tag1;
  logic          bad1;
  // stage 2: shift, denominator
  logic          v2;
  logic [31:0]   x1_2, den2;
  logic [Tw-1:0] tag2;
  logic          bad2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
    prod1 <= ({16'd0, ut} - cal.ac6) * cal.ac5;
    bad1  <= cal.ac1[15:0] == 16'hFFFF;
    tag1  <= in_tag;
    x1_2  <= bpc_pkg::asr(prod1, 15);
    den2  <= bpc_pkg::asr(prod1, 15) + cal.md;
    bad2  <= bad1;
    tag2  <= tag1;
  end

  logic [31:0] num, an, ad;
  logic        zero2;
  logic [1:0]  st2;
  assign num   = {cal.mc[20:0], 11'd0};
  assign an    = num[31] ? 32'd0 - num : num;
  assign ad    = den2[31] ? 32'd0 - den2 : den2;
  assign zero2 = den2 == 32'd0;
  assign st2   = bad2 ? bpc_pkg::ST_BAD_CAL : (zero2 ? bpc_pkg::ST_ZERO : bpc_pkg::ST_OK);

  logic          dv;
  logic [31:0]   q;
  logic [Pw-1:0] dtag;
  bpc_div #(.Tw(Pw)) u_div (
    .clk(clk), .rst(rst), .in_valid(v2), .dividend(an),
    .divisor(zero2 ? 32'd1 : ad), .negate(num[31] ^ den2[31]),
    .in_tag({tag2, x1_2, st2}), .out_valid(dv), .quotient(q), .out_tag(dtag)
  );

  logic [31:0] x1d;
  assign x1d = dtag[33:2];
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv;
    end
    b5      <= x1d + q;
    t       <= bpc_pkg::asr(x1d + q + 32'd8, 4);
    status  <= dtag[1:0];
    out_tag <= dtag[Pw-1:34];
  end
endmodule

FILE: sv/bpc_press.sv
// Pressure back end: B3/B4/B7 terms, unsigned division, final polynomial correction.
module bpc_press (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [31:0]   b5,
  input  logic [31:0]   t,
  input  logic [1:0]    status,
  input  logic [18:0]   up,
  input  bpc_pkg::cal_t cal,
  output logic          out_valid,
  output logic [1:0]    out_status,
  output logic [31:0]   out_t,
  output logic [31:0]   out_p
);
  localparam int Tw = 2 + 32 + 1;

  // rider carried along stages 1 to 5
  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] t;
    logic [18:0] up;
  } side_t;

  logic v1, v2, v3, v4, v5;
  side_t s1, s2, s3, s4, s5;
  logic [31:0] b6_1, sq2, b6_2, a_b2, a_ac2, a_ac3, a_b1;
  logic [31:0] b3_4, x3_4, b4_5, b7_5;
  logic [31:0] prod4;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5} <= '0;
    end else begin
      {v1, v2, v3, v4, v5} <= {in_valid, v1, v2, v3, v4};
    end
    s1 <= '{st: status, t: t, up: up};
    s2 <= s1; s3 <= s2; s4 <= s3; s5 <= s4;
    // stage 1: B6
    b6_1 <= b5 - 32'd4000;
    // stage 2: B6 squared
    sq2  <= b6_1 * b6_1;
    b6_2 <= b6_1;
    // stage 3: coefficient products
    a_b2  <= cal.b2 * bpc_pkg::asr(sq2, 12);
    a_b1  <= cal.b1 * bpc_pkg::asr(sq2, 12);
    a_ac2 <= cal.ac2 * b6_2;
    a_ac3 <= cal.ac3 * b6_2;
    // stage 4: B3 and X3
    b3_4 <= bpc_pkg::asr(((cal.ac1 * 32'd4 + bpc_pkg::asr(a_b2, 11)
            + bpc_pkg::asr(a_ac2, 11)) << cal.oss) + 32'd2, 2);
    x3_4 <= bpc_pkg::asr(bpc_pkg::asr(a_ac3, 13) + bpc_pkg::asr(a_b1, 16) + 32'd2, 2);
    // stage 5: B4, B7
    b4_5 <= prod4 >> 15;
    b7_5 <= ({13'd0, s4.up} - b3_4) * (32'd50000 >> cal.oss);
  end
  assign prod4 = cal.ac4 * (x3_4 + 32'd32768);

  logic zero5;
  logic [1:0] st5;
  logic [Tw-1:0] dtag;
  logic dv;
  logic [31:0] q;
  assign zero5 = b4_5 == 32'd0;
  assign st5   = (s5.st == bpc_pkg::ST_OK && zero5) ? bpc_pkg::ST_ZERO : s5.st;

  bpc_div #(.Tw(Tw)) u_div (
    .clk(clk), .rst(rst), .in_valid(v5),
    .dividend(b7_5[31] ? b7_5 : {b7_5[30:0], 1'b0}),
    .divisor(zero5 ? 32'd1 : b4_5), .negate(1'b0),
    .in_tag({st5, s5.t, b7_5[31]}), .out_valid(dv), .quotient(q), .out_tag(dtag)
  );

  // correction pipeline
  logic v6, v7, v8;
  logic [1:0] st6, st7, st8;
  logic [31:0] t6, t7, p6, p7, sqp7, lin7, x1_8, x2_8, p8;
  logic [31:0] t7_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      {v6, v7, v8} <= '0;
      out_valid    <= 1'b0;
    end else begin
      {v6, v7, v8} <= {dv, v6, v7};
      out_valid    <= v8;
    end
    st6 <= dtag[34:33]; t6 <= dtag[32:1];
    p6  <= dtag[0] ? {q[30:0], 1'b0} : q;
    st7 <= st6; t7 <= t6; p7 <= p6;
    sqp7 <= bpc_pkg::asr(p6, 8) * bpc_pkg::asr(p6, 8);
    lin7 <= (32'd0 - 32'd7357) * p6;
    st8 <= st7; p8 <= p7;
    x1_8 <= sqp7 * 32'd3038;
    x2_8 <= bpc_pkg::asr(lin7, 16);
    out_status <= st8;
    out_t      <= (st8 == bpc_pkg::ST_OK) ? t7_d : 32'd0;
    out_p      <= (st8 == bpc_pkg::ST_OK)
                  ? p8 + bpc_pkg::asr(bpc_pkg::asr(x1_8, 16) + x2_8 + 32'd3791, 4) : 32'd0;
  end
  always_ff @(posedge clk) begin
    t7_d <= t7;
  end
endmodule

FILE: sv/barometric_pressure_compensation.sv
// Top level of the barometric pressure and temperature compensation pipeline.
// Usage:
//   Load cal_word_a/b/c and oversampling through the write port (we, index,
//   wdata) while no transaction is in flight. Pulse start with raw_temperature
//   and raw_pressure; busy is always low, so a transaction is taken every
//   cycle start is high. Each transaction returns one result: done is high for
//   exactly one cycle with status, temperature_tenths and pressure_pa.
// Pipeline: 2 temperature stages, 32 divider stages and an output register,
//   then 5 pressure stages, 32 divider stages and 4 correction stages. One
//   transaction is taken per cycle; both dividers are fully pipelined at one
//   quotient bit per stage, and their 64 stages form most of the pipeline.
// Status: 0 valid, 1 AC1 is 0xFFFF, 2 zero divisor (temperature or pressure).
//   Value fields read zero when status is not 0.
// Reset: rst clears all valid bits and loads the calibration registers with all
//   ones and oversampling with 3. The receiver cannot stall: done is a strobe.
module barometric_pressure_compensation (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] raw_temperature,
  input  logic [18:0] raw_pressure,
  input  logic        we,
  input  logic [1:0]  index,
  input  logic [63:0] wdata,
  output logic        done,
  output logic [1:0]  status,
  output logic signed [31:0] temperature_tenths,
  output logic signed [31:0] pressure_pa
);
  logic [63:0] cal_word_a, cal_word_b;
  logic [31:0] cal_word_c;
  logic [1:0]  oversampling;

  // index is two bits wide, so every write lands on a register
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_word_a   <= '1;
      cal_word_b   <= '1;
      cal_word_c   <= '1;
      oversampling <= 2'd3;
    end else if (we) begin
      unique case ({2'b00, index})
        bpc_pkg::REG_CAL_A: cal_word_a   <= wdata;
        bpc_pkg::REG_CAL_B: cal_word_b   <= wdata;
        bpc_pkg::REG_CAL_C: cal_word_c   <= wdata[31:0];
        bpc_pkg::REG_OSS:   oversampling <= wdata[1:0];
        default: ;
      endcase
    end
  end

  bpc_pkg::cal_t cal;
  assign cal.ac1 = bpc_pkg::sx16(cal_word_a[15:0]);
  assign cal.ac2 = bpc_pkg::sx16(cal_word_a[31:16]);
  assign cal.ac3 = bpc_pkg::sx16(cal_word_a[47:32]);
  assign cal.ac4 = {16'd0, cal_word_a[63:48]};
  assign cal.ac5 = {16'd0, cal_word_b[15:0]};
  assign cal.ac6 = {16'd0, cal_word_b[31:16]};
  assign cal.b1  = bpc_pkg::sx16(cal_word_b[47:32]);
  assign cal.b2  = bpc_pkg::sx16(cal_word_b[63:48]);
  assign cal.mc  = bpc_pkg::sx16(cal_word_c[15:0]);
  assign cal.md  = bpc_pkg::sx16(cal_word_c[31:16]);
  assign cal.oss = oversampling;

  assign busy = 1'b0;

  // raw pressure rides through the temperature half as a tag
  logic        tv;
  logic [31:0] b5, t;
  logic [1:0]  tst;
  logic [18:0] up;
  bpc_temp #(.Tw(19)) u_temp (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .ut(raw_temperature),
    .cal(cal), .in_tag(raw_pressure), .out_valid(tv), .b5(b5), .t(t),
    .status(tst), .out_tag(up)
  );

  logic [31:0] tt, pp;
  bpc_press u_press (
    .clk(clk), .rst(rst), .in_valid(tv), .b5(b5), .t(t), .status(tst), .up(up),
    .cal(cal), .out_valid(done), .out_status(status), .out_t(tt), .out_p(pp)
  );
  assign temperature_tenths = tt;
  assign pressure_pa        = pp;

`ifndef ASSERT_OFF
  // Results carry zero values whenever status flags a problem.
  a_zero_on_err: assert property (@(posedge clk) disable iff (rst)
    done && status != bpc_pkg::ST_OK |-> temperature_tenths == 0 && pressure_pa == 0)
    else $error("nonzero value with error status");
  // Status never takes the unused code.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status != 2'd3) else $error("bad status code");
  // The block never reports busy.
  a_never_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
`endif
endmodule
